[design/assert_macros.svh]
// Assertion macros used by segment_intersection_test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property, switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked implication from an antecedent to a consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[design/sit_pkg.sv]
package sit_pkg;

  // Number of register stages an item passes before the result register.
  localparam int unsigned FILL_STAGES = 3;

  // Orientation of a point relative to a directed segment.
  typedef enum logic [1:0] {
    TURN_COL = 2'd0,
    TURN_POS = 2'd1,
    TURN_NEG = 2'd2
  } turn_t;

  // The four orientations of one item.
  typedef struct packed {
    turn_t t1;
    turn_t t2;
    turn_t t3;
    turn_t t4;
  } turns_t;

  // Bounding-box containment of each endpoint in the other segment's box.
  typedef struct packed {
    logic c_in_ab;
    logic d_in_ab;
    logic a_in_cd;
    logic b_in_cd;
  } box_flags_t;

endpackage

[design/segment_intersection_test.sv]
// Segment intersection test. A pair of segments is taken whenever start is
// high; busy never rises, so one item can enter in every cycle. The result
// appears on out_intersects with out_valid high for one cycle, four cycles
// after the item was taken, and the receiver must take it then. The latency
// is set by the four register stages: coordinate differences, the exact
// cross-product multiplies, the product compare, and the result register.
`include "assert_macros.svh"

module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_first_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_end_y,
  output logic                          out_valid,
  output logic                          out_intersects
);

  logic                          in_acc;
  logic [sit_pkg::FILL_STAGES-1:0] vld_r, vld_nxt;
  sit_pkg::turns_t               turns;
  sit_pkg::box_flags_t           box;

  // The pipeline never stalls, so the input side is always open.
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // Valid bits travel alongside the item through the stages.
  assign vld_nxt = {vld_r[sit_pkg::FILL_STAGES-2:0], in_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Orientation of the second segment's endpoints about the first segment.
  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient1 (
    .clk (clk),
    .a_x (in_first_start_x),  .a_y (in_first_start_y),
    .b_x (in_first_end_x),    .b_y (in_first_end_y),
    .c_x (in_second_start_x), .c_y (in_second_start_y),
    .turn(turns.t1)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient2 (
    .clk (clk),
    .a_x (in_first_start_x), .a_y (in_first_start_y),
    .b_x (in_first_end_x),   .b_y (in_first_end_y),
    .c_x (in_second_end_x),  .c_y (in_second_end_y),
    .turn(turns.t2)
  );

  // Orientation of the first segment's endpoints about the second segment.
  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient3 (
    .clk (clk),
    .a_x (in_second_start_x), .a_y (in_second_start_y),
    .b_x (in_second_end_x),   .b_y (in_second_end_y),
    .c_x (in_first_start_x),  .c_y (in_first_start_y),
    .turn(turns.t3)
  );

  sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient4 (
    .clk (clk),
    .a_x (in_second_start_x), .a_y (in_second_start_y),
    .b_x (in_second_end_x),   .b_y (in_second_end_y),
    .c_x (in_first_end_x),    .c_y (in_first_end_y),
    .turn(turns.t4)
  );

  // Bounding-box tests for the collinear cases.
  sit_box #(.COORD_WIDTH(COORD_WIDTH)) u_box (
    .clk  (clk),
    .a_x  (in_first_start_x),  .a_y (in_first_start_y),
    .b_x  (in_first_end_x),    .b_y (in_first_end_y),
    .c_x  (in_second_start_x), .c_y (in_second_start_y),
    .d_x  (in_second_end_x),   .d_y (in_second_end_y),
    .flags(box)
  );

  // Final decision and result register.
  sit_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (vld_r[sit_pkg::FILL_STAGES-1]),
    .turns     (turns),
    .box       (box),
    .out_valid (out_valid),
    .intersects(out_intersects)
  );

  // Every result strobe stems from an item taken into the pipeline.
  `ASSERT_CLK(a_out_from_item, out_valid |-> $past(in_acc, 4), "result without item")

  // Segments that share their start point always touch.
  `ASSERT_IMP(a_shared_start, out_valid && $past(in_acc && (in_first_start_x == in_second_start_x) && (in_first_start_y == in_second_start_y), 4), out_intersects, "shared endpoint missed")

endmodule

[design/sit_orient.sv]
module sit_orient #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  output sit_pkg::turn_t                turn
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] dy_ab_r, dx_bc_r, dx_ab_r, dy_bc_r;
  logic signed [PW-1:0] lhs_r, rhs_r;
  sit_pkg::turn_t       turn_r, turn_nxt;

  // Stage one: coordinate differences, one bit wider than the coordinates.
  always_ff @(posedge clk) begin
    dy_ab_r <= {b_y[COORD_WIDTH-1], b_y} - {a_y[COORD_WIDTH-1], a_y};
    dx_bc_r <= {c_x[COORD_WIDTH-1], c_x} - {b_x[COORD_WIDTH-1], b_x};
    dx_ab_r <= {b_x[COORD_WIDTH-1], b_x} - {a_x[COORD_WIDTH-1], a_x};
    dy_bc_r <= {c_y[COORD_WIDTH-1], c_y} - {b_y[COORD_WIDTH-1], b_y};
  end

  // Stage two: the two exact products of the cross term.
  always_ff @(posedge clk) begin
    lhs_r <= dy_ab_r * dx_bc_r;
    rhs_r <= dx_ab_r * dy_bc_r;
  end

  // Stage three: the sign of the cross term, found by comparing the products.
  always_comb begin
    if (lhs_r == rhs_r) begin
      turn_nxt = sit_pkg::TURN_COL;
    end else if (lhs_r > rhs_r) begin
      turn_nxt = sit_pkg::TURN_POS;
    end else begin
      turn_nxt = sit_pkg::TURN_NEG;
    end
  end

  always_ff @(posedge clk) begin
    turn_r <= turn_nxt;
  end

  assign turn = turn_r;

endmodule

[design/sit_box.sv]
module sit_box #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] d_x,
  input  logic signed [COORD_WIDTH-1:0] d_y,
  output sit_pkg::box_flags_t           flags
);

  sit_pkg::box_flags_t flags_nxt;
  sit_pkg::box_flags_t s1_r, s2_r, s3_r;

  // True when t lies between p and q, in either order.
  function automatic logic between(input logic signed [COORD_WIDTH-1:0] p,
                                   input logic signed [COORD_WIDTH-1:0] t,
                                   input logic signed [COORD_WIDTH-1:0] q);
    between = ((t >= p) && (t <= q)) || ((t >= q) && (t <= p));
  endfunction

  // Each endpoint tested against the bounding box of the other segment.
  always_comb begin
    flags_nxt.c_in_ab = between(a_x, c_x, b_x) && between(a_y, c_y, b_y);
    flags_nxt.d_in_ab = between(a_x, d_x, b_x) && between(a_y, d_y, b_y);
    flags_nxt.a_in_cd = between(c_x, a_x, d_x) && between(c_y, a_y, d_y);
    flags_nxt.b_in_cd = between(c_x, b_x, d_x) && between(c_y, b_y, d_y);
  end

  // The flags are ready early, so they ride alongside the orientation stages.
  always_ff @(posedge clk) begin
    s1_r <= flags_nxt;
    s2_r <= s1_r;
    s3_r <= s2_r;
  end

  assign flags = s3_r;

endmodule

[design/sit_decide.sv]
module sit_decide (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid,
  input  sit_pkg::turns_t     turns,
  input  sit_pkg::box_flags_t box,
  output logic                out_valid,
  output logic                intersects
);

  logic valid_r;
  logic hit_r, hit_nxt;
  logic proper, touch;

  // A proper crossing, or an endpoint collinear with and inside the other segment.
  always_comb begin
    proper = (turns.t1 != turns.t2) && (turns.t3 != turns.t4);
    touch  = ((turns.t1 == sit_pkg::TURN_COL) && box.c_in_ab) ||
             ((turns.t2 == sit_pkg::TURN_COL) && box.d_in_ab) ||
             ((turns.t3 == sit_pkg::TURN_COL) && box.a_in_cd) ||
             ((turns.t4 == sit_pkg::TURN_COL) && box.b_in_cd);
    hit_nxt = proper || touch;
  end

  // Result register: the strobe is control, the flag is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  assign out_valid  = valid_r;
  assign intersects = hit_r;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int COORD_W = 16;
  localparam int RESULT_LATENCY = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PAIRS = 830;
  localparam int CALM_TAIL = 150;
  localparam int MAX_REPORTS = 100;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One item: the two endpoints of each segment.
  typedef struct {
    coord_t ax, ay, bx, by;
    coord_t cx, cy, dx, dy;
  } seg_pair_t;

  // An expected result together with the item that caused it.
  typedef struct {
    seg_pair_t pair;
    logic      hit;
  } contact_t;

  logic   clk;
  logic   rst_n;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_first_start_x = '0;
  coord_t in_first_start_y = '0;
  coord_t in_first_end_x = '0;
  coord_t in_first_end_y = '0;
  coord_t in_second_start_x = '0;
  coord_t in_second_start_y = '0;
  coord_t in_second_end_x = '0;
  coord_t in_second_end_y = '0;
  logic   out_valid;
  logic   out_intersects;

  seg_pair_t pending_pairs[$];
  contact_t  contact_expect_q[$];
  seg_pair_t driven_pair;
  contact_t  oldest;
  int        idle_left = 0;
  int        accepted_cnt = 0;
  int        total_pairs = 0;
  int        directed_cnt = 0;
  int        checked_cnt = 0;
  int        contact_cnt = 0;
  int        error_cnt = 0;
  int        stall_cycles = 0;

  segment_intersection_test #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_start_x (in_first_start_x),
    .in_first_start_y (in_first_start_y),
    .in_first_end_x   (in_first_end_x),
    .in_first_end_y   (in_first_end_y),
    .in_second_start_x(in_second_start_x),
    .in_second_start_y(in_second_start_y),
    .in_second_end_x  (in_second_end_x),
    .in_second_end_y  (in_second_end_y),
    .out_valid        (out_valid),
    .out_intersects   (out_intersects)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sign of the cross product of (b - a) and (c - b), found by comparing the
  // two exact products.
  function automatic sit_pkg::turn_t orientation_of(longint ax, longint ay, longint bx,
                                                    longint by, longint cx, longint cy);
    longint lhs;
    longint rhs;
    lhs = (by - ay) * (cx - bx);
    rhs = (bx - ax) * (cy - by);
    if (lhs == rhs) return sit_pkg::TURN_COL;
    return (lhs > rhs) ? sit_pkg::TURN_POS : sit_pkg::TURN_NEG;
  endfunction

  // True when point t lies in the bounding box spanned by a and b.
  function automatic bit within_box(longint ax, longint ay, longint tx, longint ty,
                                    longint bx, longint by);
    longint xlo, xhi, ylo, yhi;
    xlo = (ax < bx) ? ax : bx;
    xhi = (ax < bx) ? bx : ax;
    ylo = (ay < by) ? ay : by;
    yhi = (ay < by) ? by : ay;
    return tx >= xlo && tx <= xhi && ty >= ylo && ty <= yhi;
  endfunction

  // Expected contact flag for one pair of segments.
  function automatic logic predict_contact(seg_pair_t p);
    longint         ax, ay, bx, by, cx, cy, dx, dy;
    sit_pkg::turn_t t1, t2, t3, t4;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
    t1 = orientation_of(ax, ay, bx, by, cx, cy);
    t2 = orientation_of(ax, ay, bx, by, dx, dy);
    t3 = orientation_of(cx, cy, dx, dy, ax, ay);
    t4 = orientation_of(cx, cy, dx, dy, bx, by);
    if (t1 != t2 && t3 != t4) return 1'b1;
    if (t1 == sit_pkg::TURN_COL && within_box(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (t2 == sit_pkg::TURN_COL && within_box(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (t3 == sit_pkg::TURN_COL && within_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (t4 == sit_pkg::TURN_COL && within_box(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  // Coordinates are given as integers and cut to the port width.
  task automatic queue_pair(input int ax, input int ay, input int bx, input int by,
                            input int cx, input int cy, input int dx, input int dy);
    seg_pair_t p;
    p.ax = ax[COORD_W-1:0]; p.ay = ay[COORD_W-1:0];
    p.bx = bx[COORD_W-1:0]; p.by = by[COORD_W-1:0];
    p.cx = cx[COORD_W-1:0]; p.cy = cy[COORD_W-1:0];
    p.dx = dx[COORD_W-1:0]; p.dy = dy[COORD_W-1:0];
    pending_pairs.push_back(p);
  endtask

  function automatic int full_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Arbitrary values in half of the draws, with the range limits and the values
  // around zero turning up in the rest.
  function automatic int edgy_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return -int'($urandom_range(0, 1));
      default: return full_coord();
    endcase
  endfunction

  // One random item. Besides unrelated segments, the mix builds the shapes
  // that reach the collinear and touching paths: points on one line, an
  // endpoint on the other segment, degenerate segments and shared endpoints.
  task automatic add_random_pair();
    int ox, oy, ux, uy, k, j, px, py, qx, qy;
    int s0, s1, s2, s3;
    ox = int'($urandom_range(0, 60000)) - 30000;
    oy = int'($urandom_range(0, 60000)) - 30000;
    ux = offset(40);
    uy = offset(40);
    k = $urandom_range(0, 8);
    j = $urandom_range(0, k);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        queue_pair(full_coord(), full_coord(), full_coord(), full_coord(),
                   full_coord(), full_coord(), full_coord(), full_coord());
      end
      3, 4: begin
        queue_pair(ox + offset(6), oy + offset(6), ox + offset(6), oy + offset(6),
                   ox + offset(6), oy + offset(6), ox + offset(6), oy + offset(6));
      end
      5: begin
        // All four points on one line through the origin point.
        ux = offset(4);
        uy = offset(4);
        s0 = offset(6); s1 = offset(6); s2 = offset(6); s3 = offset(6);
        queue_pair(ox + s0 * ux, oy + s0 * uy, ox + s1 * ux, oy + s1 * uy,
                   ox + s2 * ux, oy + s2 * uy, ox + s3 * ux, oy + s3 * uy);
      end
      6: begin
        // An endpoint of one segment on the other, the far end anywhere near.
        px = ox + j * ux;
        py = oy + j * uy;
        qx = ox + offset(300);
        qy = oy + offset(300);
        if ($urandom_range(0, 1))
          queue_pair(ox, oy, ox + k * ux, oy + k * uy, px, py, qx, qy);
        else
          queue_pair(qx, qy, px, py, ox + k * ux, oy + k * uy, ox, oy);
      end
      7: begin
        // A segment shrunk to a point, either on the other segment or just off.
        px = ox + j * ux + $urandom_range(0, 1);
        py = oy + j * uy;
        if ($urandom_range(0, 1))
          queue_pair(px, py, px, py, ox, oy, ox + k * ux, oy + k * uy);
        else
          queue_pair(ox, oy, ox + k * ux, oy + k * uy, px, py, px, py);
      end
      8: begin
        queue_pair(edgy_coord(), edgy_coord(), edgy_coord(), edgy_coord(),
                   edgy_coord(), edgy_coord(), edgy_coord(), edgy_coord());
      end
      default: begin
        // Two segments sharing one endpoint.
        px = ox + offset(20);
        py = oy + offset(20);
        qx = ox + offset(20);
        qy = oy + offset(20);
        if ($urandom_range(0, 1))
          queue_pair(ox, oy, px, py, px, py, qx, qy);
        else
          queue_pair(ox, oy, px, py, qx, qy, ox, oy);
      end
    endcase
  endtask

  // Driver: presents the next item from the queue, holds it while busy is
  // high, and records the expected result when the item is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        contact_expect_q.push_back('{pair: driven_pair, hit: predict_contact(driven_pair)});
        accepted_cnt++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          start <= 1'b0;
          idle_left--;
        end else if (pending_pairs.size() != 0) begin
          driven_pair = pending_pairs.pop_front();
          in_first_start_x  <= driven_pair.ax;
          in_first_start_y  <= driven_pair.ay;
          in_first_end_x    <= driven_pair.bx;
          in_first_end_y    <= driven_pair.by;
          in_second_start_x <= driven_pair.cx;
          in_second_start_y <= driven_pair.cy;
          in_second_end_x   <= driven_pair.dx;
          in_second_end_y   <= driven_pair.dy;
          start <= 1'b1;
          // Gaps come in bursts during alternate stretches of the run, and
          // never near its end.
          if (pending_pairs.size() > CALM_TAIL && (pending_pairs.size() / 64) % 2 == 0 &&
              $urandom_range(0, 2) == 0)
            idle_left = $urandom_range(1, 3);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        error_cnt++;
        $display("%0t: out_valid is unknown", $time);
      end else if (out_valid) begin
        if (contact_expect_q.size() == 0) begin
          error_cnt++;
          $display("%0t: result %b arrived with no item outstanding", $time, out_intersects);
        end else begin
          oldest = contact_expect_q.pop_front();
          checked_cnt++;
          if (oldest.hit) contact_cnt++;
          if (out_intersects !== oldest.hit) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
              $display({"%0t: intersects expected %b actual %b ",
                        "for (%0d,%0d)-(%0d,%0d) (%0d,%0d)-(%0d,%0d)"},
                       $time, oldest.hit, out_intersects,
                       oldest.pair.ax, oldest.pair.ay, oldest.pair.bx, oldest.pair.by,
                       oldest.pair.cx, oldest.pair.cy, oldest.pair.dx, oldest.pair.dy);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid === 1'b1)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("segment_intersection_test verification failed");
        $finish;
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin
    rst_n = 1'b0;

    // Directed items: range limits, proper crossings, touching, collinear
    // overlap and separation, and degenerate segments.
    queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
    queue_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    queue_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    queue_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
    queue_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    queue_pair(0, 0, 4, 4, 0, 4, 4, 0);
    queue_pair(0, 0, 4, 0, 2, 0, 2, 5);
    queue_pair(0, 0, 4, 0, 2, 1, 2, 5);
    queue_pair(0, 0, 4, 4, 2, 2, 6, 6);
    queue_pair(0, 0, 2, 2, 3, 3, 5, 5);
    queue_pair(0, 0, 2, 2, 2, 2, 5, 5);
    queue_pair(1, 1, 1, 1, 0, 0, 3, 3);
    queue_pair(1, 2, 1, 2, 0, 0, 3, 3);
    queue_pair(0, 0, 3, 3, 2, 2, 2, 2);
    queue_pair(1, 1, 1, 1, 2, 2, 2, 2);
    queue_pair(-32768, 5, -100, 5, 100, 5, 32767, 5);
    queue_pair(0, 0, 3, 1, 3, 1, 5, 7);
    queue_pair(-1, -1, 0, 0, -1, 0, 0, -1);
    queue_pair(7, -32768, 7, 32767, 7, 0, 7, 1);
    queue_pair('h5555, 'hAAAA, 'hAAAA, 'h5555, 'h5555, 'h5555, 'hAAAA, 'hAAAA);
    directed_cnt = pending_pairs.size();

    repeat (RANDOM_PAIRS) add_random_pair();
    total_pairs = pending_pairs.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_pairs || contact_expect_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 4) @(posedge clk);

    $display("Drove %0d segment pairs (%0d directed, %0d random) with gaps on the input side.",
             accepted_cnt, directed_cnt, accepted_cnt - directed_cnt);
    $display("Checked %0d results: %0d contacts, %0d misses, %0d errors.",
             checked_cnt, contact_cnt, checked_cnt - contact_cnt, error_cnt);
    if (error_cnt == 0)
      $display("segment_intersection_test verification clean");
    else
      $display("segment_intersection_test verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/sit_pkg.sv
design/sit_orient.sv
design/sit_box.sv
design/sit_decide.sv
design/segment_intersection_test.sv
sim/tb.sv
